// ----- rtl/core/spl_pkg.sv -----
// ============================================================================
// spl_pkg: shared types and constants for the stereo peak limiter
// Widths, register map, reset values and sequencer states.
// ============================================================================
package spl_pkg;

    localparam int SAMPLE_W = 24;   // Q1.23 audio sample
    localparam int MAG_W    = 24;   // magnitude of one sample, up to 2^23
    localparam int SUM_W    = 25;   // magnitude of L+R, up to 2^24
    localparam int GAIN_W   = 31;   // gain, 1.0 = 2^30
    localparam int THR_W    = 28;   // threshold and trim, 1.0 = 2^24
    localparam int RATE_W   = 31;   // attack / release, 1.0 = 2^30
    localparam int GT_W     = 35;   // trim times gain, 1.0 = 2^30
    localparam int MUL_W    = 32;   // shared multiplier operand width
    localparam int PROD_W   = 64;   // shared multiplier product width
    localparam int DEN_W    = 36;   // soft-knee denominator, 1.0 = 2^30
    localparam int QUO_W    = 31;   // reciprocal quotient, at most 2^30
    localparam int CNT_W    = 5;    // quotient bit counter
    localparam int ADDR_W   = 5;    // APB byte address
    localparam int DATA_W   = 32;   // APB data

    localparam logic [GAIN_W-1:0] GAIN_ONE = 31'h4000_0000;

    // remainder seed: dividend 2^60 with its upper bits already shifted in
    localparam logic [DEN_W-1:0] RECIP_REM_INIT = 36'h0_2000_0000;

    // register map, word index
    localparam logic [2:0] REG_SOFT_KNEE = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_TRIM      = 3'd4;

    localparam logic              RST_SOFT_KNEE = 1'b0;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 28'd2642147;
    localparam logic [RATE_W-1:0] RST_ATTACK    = 31'd649950000;
    localparam logic [RATE_W-1:0] RST_RELEASE   = 31'd339547;
    localparam logic [THR_W-1:0]  RST_TRIM      = 28'd26591549;

    localparam logic [SAMPLE_W-1:0] OUT_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] OUT_MIN = 24'h80_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_COMPARE,
        ST_DENOM,
        ST_DIVIDE,
        ST_TARGET,
        ST_STEP,
        ST_UPDATE,
        ST_TRIM,
        ST_SCALE,
        ST_CH_LO,
        ST_CH_HI,
        ST_CH_SUM,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/spl_recip.sv -----
// ============================================================================
// spl_recip: iterative reciprocal unit
// Computes floor(2^60 / divisor) for divisor >= 2^30, one quotient bit a cycle.
// ============================================================================
module spl_recip
    import spl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DEN_W-1:0] div_reg,  div_next;
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_comb begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            div_next  = divisor;
            rem_next  = RECIP_REM_INIT;
            quo_next  = '0;
            cnt_next  = CNT_W'(QUO_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // restoring step; dividend bits below the seed are all zero
            rem_next = fits ? DEN_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    // divisor is at least 1.0, so the reciprocal never exceeds 1.0
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (quo_reg <= GAIN_ONE))
        else $error("reciprocal above unity");
`endif

endmodule

// ----- rtl/core/stereo_peak_limiter.sv -----
// ============================================================================
// stereo_peak_limiter: feedback peak limiter for stereo sample pairs
// One smoothed gain, hard or soft knee, trimmed and saturated outputs.
// ============================================================================
// Usage:
//   s_ channel carries one stereo word (left, right, Q1.23). m_ channel
//   returns the limited pair plus the updated gain (1.0 = 2^30). Both use
//   valid/ready. Settings sit in an APB register file (knee, threshold,
//   attack, release, trim); write them only while the block is idle.
//   Operation: one word at a time through a single 32x32 multiplier under a
//   sequencer. Soft knee adds a divide in the reciprocal unit, which resolves
//   one quotient bit per cycle. The result goes to an output register:
//   s_ready returns while it waits, and a stalled receiver only holds the
//   next word at its final step.
//   Reset (aresetn low, synchronous) restores register defaults, sets the
//   gain to 1.0 and empties the output register.
// ============================================================================
module stereo_peak_limiter
    import spl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    // result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out,
    output logic        [GAIN_W-1:0]   m_gain_now,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [ADDR_W-1:0]   paddr,
    input  logic        [DATA_W-1:0]   pwdata,
    output logic        [DATA_W-1:0]   prdata,
    output logic                       pready
);

    // configuration registers
    logic              knee_reg,    knee_next;
    logic [THR_W-1:0]  thr_reg,     thr_next;
    logic [RATE_W-1:0] attack_reg,  attack_next;
    logic [RATE_W-1:0] release_reg, release_next;
    logic [THR_W-1:0]  trim_reg,    trim_next;

    // control
    state_t            state_reg,   state_next;
    logic [GAIN_W-1:0] gain_reg,    gain_next;
    logic              m_valid_reg, m_valid_next;
    logic              ch_reg,      ch_next;
    logic              down_reg,    down_next;

    // datapath
    logic [MAG_W-1:0]    mag_l_reg,  mag_l_next;
    logic [MAG_W-1:0]    mag_r_reg,  mag_r_next;
    logic                neg_l_reg,  neg_l_next;
    logic                neg_r_reg,  neg_r_next;
    logic [SUM_W-1:0]    sum_reg,    sum_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    logic [GAIN_W-1:0]   diff_reg,   diff_next;
    logic [GT_W-1:0]     gt_reg,     gt_next;
    logic [MAG_W-1:0]    acc_reg,    acc_next;
    logic [SAMPLE_W-1:0] res_l_reg,  res_l_next;
    logic [SAMPLE_W-1:0] res_r_reg,  res_r_next;
    logic [SAMPLE_W-1:0] m_left_reg, m_left_next;
    logic [SAMPLE_W-1:0] m_right_reg, m_right_next;
    logic [GAIN_W-1:0]   m_gain_reg, m_gain_next;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              mul_en;

    // reciprocal unit
    logic              recip_start;
    logic              recip_done;
    logic [QUO_W-1:0]  recip_quot;
    logic [DEN_W-1:0]  denom;

    // helpers
    logic signed [SUM_W-1:0] in_sum;
    logic signed [SUM_W-1:0] l_ext, r_ext;
    logic [57:0]       lev_ext, thr_ext, excess;
    logic              over;
    logic [MUL_W-1:0]  delta;
    logic [GAIN_W+1:0] up_sum;
    logic [GAIN_W-1:0] gain_dn, gain_up;
    logic [MAG_W-1:0]  ch_mag;
    logic              ch_neg;
    logic [28:0]       total;
    logic [SAMPLE_W-1:0] ch_res;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    spl_recip u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (recip_start),
        .divisor  (denom),
        .done     (recip_done),
        .quotient (recip_quot)
    );

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        knee_next    = knee_reg;
        thr_next     = thr_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        trim_next    = trim_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_SOFT_KNEE: knee_next    = pwdata[0];
                REG_THRESHOLD: thr_next     = pwdata[THR_W-1:0];
                REG_ATTACK:    attack_next  = pwdata[RATE_W-1:0];
                REG_RELEASE:   release_next = pwdata[RATE_W-1:0];
                REG_TRIM:      trim_next    = pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SOFT_KNEE: prdata = {{(DATA_W-1){1'b0}}, knee_reg};
            REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, thr_reg};
            REG_ATTACK:    prdata = {{(DATA_W-RATE_W){1'b0}}, attack_reg};
            REG_RELEASE:   prdata = {{(DATA_W-RATE_W){1'b0}}, release_reg};
            REG_TRIM:      prdata = {{(DATA_W-THR_W){1'b0}}, trim_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    assign l_ext  = SUM_W'(s_left_in);
    assign r_ext  = SUM_W'(s_right_in);
    assign in_sum = l_ext + r_ext;

    // hard-knee level test: S*g against threshold*2^30
    assign lev_ext = {3'b000, prod_reg[54:0]};
    assign thr_ext = {thr_reg, 30'd0};
    assign over    = lev_ext > thr_ext;
    assign excess  = lev_ext - thr_ext;

    assign denom = {{(DEN_W-GAIN_W){1'b0}}, GAIN_ONE} + prod_reg[52:17];

    // gain step, clamped to [0, 1.0]
    assign delta   = prod_reg[61:30];
    assign gain_dn = ({1'b0, delta} >= {2'b00, gain_reg}) ? '0
                                                          : gain_reg - delta[GAIN_W-1:0];
    assign up_sum  = {2'b00, gain_reg} + {1'b0, delta};
    assign gain_up = (up_sum > {2'b00, GAIN_ONE}) ? GAIN_ONE : up_sum[GAIN_W-1:0];

    // per-channel output: truncate toward zero, then saturate
    assign ch_mag = ch_reg ? mag_r_reg : mag_l_reg;
    assign ch_neg = ch_reg ? neg_r_reg : neg_l_reg;
    assign total  = {5'd0, acc_reg} + prod_reg[28:0];

    always_comb begin
        if (ch_neg) begin
            ch_res = (total > 29'h80_0000) ? OUT_MIN : SAMPLE_W'(-total[SAMPLE_W-1:0]);
        end else begin
            ch_res = (total > {5'd0, OUT_MAX}) ? OUT_MAX : total[SAMPLE_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        ch_next      = ch_reg;
        down_next    = down_reg;
        mag_l_next   = mag_l_reg;
        mag_r_next   = mag_r_reg;
        neg_l_next   = neg_l_reg;
        neg_r_next   = neg_r_reg;
        sum_next     = sum_reg;
        diff_next    = diff_reg;
        gt_next      = gt_reg;
        acc_next     = acc_reg;
        res_l_next   = res_l_reg;
        res_r_next   = res_r_reg;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        m_gain_next  = m_gain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_a        = '0;
        mul_b        = '0;
        mul_en       = 1'b0;
        recip_start  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_l_next = s_left_in[SAMPLE_W-1] ? MAG_W'(-l_ext) : MAG_W'(l_ext);
                    mag_r_next = s_right_in[SAMPLE_W-1] ? MAG_W'(-r_ext) : MAG_W'(r_ext);
                    neg_l_next = s_left_in[SAMPLE_W-1];
                    neg_r_next = s_right_in[SAMPLE_W-1];
                    sum_next   = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                mul_en = 1'b1;
                if (knee_reg) begin
                    mul_a      = {{(MUL_W-THR_W){1'b0}}, thr_reg};
                    mul_b      = {{(MUL_W-SUM_W){1'b0}}, sum_reg};
                    state_next = ST_DENOM;
                end else begin
                    mul_a      = {{(MUL_W-SUM_W){1'b0}}, sum_reg};
                    mul_b      = {{(MUL_W-GAIN_W){1'b0}}, gain_reg};
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                down_next  = over;
                diff_next  = over ? excess[54:24] : GAIN_ONE - gain_reg;
                state_next = ST_STEP;
            end
            ST_DENOM: begin
                recip_start = 1'b1;
                state_next  = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (recip_done) begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET: begin
                down_next  = gain_reg > recip_quot;
                diff_next  = (gain_reg > recip_quot) ? gain_reg - recip_quot
                                                     : recip_quot - gain_reg;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                mul_en     = 1'b1;
                mul_a      = {{(MUL_W-RATE_W){1'b0}}, down_reg ? attack_reg : release_reg};
                mul_b      = {{(MUL_W-GAIN_W){1'b0}}, diff_reg};
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                gain_next  = down_reg ? gain_dn : gain_up;
                state_next = ST_TRIM;
            end
            ST_TRIM: begin
                mul_en     = 1'b1;
                mul_a      = {{(MUL_W-THR_W){1'b0}}, trim_reg};
                mul_b      = {{(MUL_W-GAIN_W){1'b0}}, gain_reg};
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                gt_next    = prod_reg[58:24];
                ch_next    = 1'b0;
                state_next = ST_CH_LO;
            end
            ST_CH_LO: begin
                // low 30 bits of the scale factor first
                mul_en     = 1'b1;
                mul_a      = {{(MUL_W-MAG_W){1'b0}}, ch_mag};
                mul_b      = {2'b00, gt_reg[29:0]};
                state_next = ST_CH_HI;
            end
            ST_CH_HI: begin
                acc_next   = prod_reg[53:30];
                mul_en     = 1'b1;
                mul_a      = {{(MUL_W-MAG_W){1'b0}}, ch_mag};
                mul_b      = {{(MUL_W-5){1'b0}}, gt_reg[GT_W-1:30]};
                state_next = ST_CH_SUM;
            end
            ST_CH_SUM: begin
                if (ch_reg) begin
                    res_r_next = ch_res;
                    state_next = ST_DONE;
                end else begin
                    res_l_next = ch_res;
                    ch_next    = 1'b1;
                    state_next = ST_CH_LO;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_left_next  = res_l_reg;
                    m_right_next = res_r_reg;
                    m_gain_next  = gain_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign prod_next = mul_en ? {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_b}
                              : prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_ONE;
            m_valid_reg <= 1'b0;
            ch_reg      <= 1'b0;
            down_reg    <= 1'b0;
            knee_reg    <= RST_SOFT_KNEE;
            thr_reg     <= RST_THRESHOLD;
            attack_reg  <= RST_ATTACK;
            release_reg <= RST_RELEASE;
            trim_reg    <= RST_TRIM;
        end else begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
            ch_reg      <= ch_next;
            down_reg    <= down_next;
            knee_reg    <= knee_next;
            thr_reg     <= thr_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            trim_reg    <= trim_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_l_reg   <= mag_l_next;
        mag_r_reg   <= mag_r_next;
        neg_l_reg   <= neg_l_next;
        neg_r_reg   <= neg_r_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        diff_reg    <= diff_next;
        gt_reg      <= gt_next;
        acc_reg     <= acc_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
        m_gain_reg  <= m_gain_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;
    assign m_gain_now  = m_gain_reg;

`ifndef SYNTHESIS
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= GAIN_ONE)
        else $error("smoothed gain above unity");

    a_gain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(gain_reg))
        else $error("gain changed outside its update step");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised without a finished item");
`endif

endmodule
